// ----- sv/bpcc_pkg.sv -----
// Package with shared constants, types and helper functions of the box/plane contact block.
package bpcc_pkg;

  localparam int unsigned PosFracBitsDefault = 16;
  localparam int unsigned MarginReset        = 655;
  localparam logic signed [31:0] One30       = 32'sd1073741824;
  localparam int unsigned QueueDepth         = 4;

  typedef enum logic [2:0] {
    CfgMargin = 3'd0,
    CfgPpX    = 3'd1,
    CfgPpY    = 3'd2,
    CfgPpZ    = 3'd3,
    CfgNX     = 3'd4,
    CfgNY     = 3'd5,
    CfgNZ     = 3'd6
  } cfg_idx_e;

  // One box after the front end: rotation matrix and inputs passed on.
  typedef struct packed {
    logic        [15:0]      tag;
    logic signed [2:0][31:0] pos;
    logic        [2:0][30:0] dim;
    logic signed [8:0][31:0] rmat;
  } box_t;

  // Plane registers as seen by the back end.
  typedef struct packed {
    logic        [30:0]      margin;
    logic signed [2:0][31:0] pp;
    logic signed [2:0][31:0] nn;
  } plane_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] clamp_r(input logic signed [35:0] v);
    if (v > 36'sd1073741824) begin
      return 32'sd1073741824;
    end else if (v < -36'sd1073741824) begin
      return -32'sd1073741824;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ----- sv/bpcc_front.sv -----
// Front end: accepts boxes and builds the clamped rotation matrix in two stages.
module bpcc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [15:0]              pair_tag_i,
  input  logic signed [31:0]       box_px_i,
  input  logic signed [31:0]       box_py_i,
  input  logic signed [31:0]       box_pz_i,
  input  logic signed [31:0]       rot_w_i,
  input  logic signed [31:0]       rot_x_i,
  input  logic signed [31:0]       rot_y_i,
  input  logic signed [31:0]       rot_z_i,
  input  logic [30:0]              size_x_i,
  input  logic [30:0]              size_y_i,
  input  logic [30:0]              size_z_i,
  output logic                     box_valid_o,
  input  logic                     box_stall_i,
  output bpcc_pkg::box_t           box_o
);

  logic                    s1_vld_q, s1_vld_d, s2_vld_q, s2_vld_d;
  logic                    adv1, adv2;
  logic        [15:0]      s1_tag_q;
  logic signed [2:0][31:0] s1_pos_q;
  logic        [2:0][30:0] s1_dim_q;
  // Products xx yy zz xy xz yz wx wy wz, floor-shifted by 30.
  logic signed [8:0][33:0] s1_prd_q, s1_prd_d;
  bpcc_pkg::box_t          s2_q, s2_d;

  assign adv2     = !s2_vld_q || !box_stall_i;
  assign adv1     = !s1_vld_q || adv2;
  assign in_stall = !adv1;

  always_comb begin
    logic signed [63:0] p [9];
    p[0] = rot_x_i * rot_x_i;
    p[1] = rot_y_i * rot_y_i;
    p[2] = rot_z_i * rot_z_i;
    p[3] = rot_x_i * rot_y_i;
    p[4] = rot_x_i * rot_z_i;
    p[5] = rot_y_i * rot_z_i;
    p[6] = rot_w_i * rot_x_i;
    p[7] = rot_w_i * rot_y_i;
    p[8] = rot_w_i * rot_z_i;
    for (int i = 0; i < 9; i++) begin
      s1_prd_d[i] = p[i][63:30];
    end
  end

  // Sums of two products reach 2^34 after doubling, hence 36 bits.
  always_comb begin
    logic signed [35:0] e [9];
    logic signed [35:0] pr [9];
    s2_d     = s2_q;
    for (int i = 0; i < 9; i++) begin
      pr[i] = 36'($signed(s1_prd_q[i]));
    end
    e[0] = 36'(bpcc_pkg::One30) - 36'sd2 * (pr[1] + pr[2]);
    e[1] = 36'sd2 * (pr[3] - pr[8]);
    e[2] = 36'sd2 * (pr[4] + pr[7]);
    e[3] = 36'sd2 * (pr[3] + pr[8]);
    e[4] = 36'(bpcc_pkg::One30) - 36'sd2 * (pr[0] + pr[2]);
    e[5] = 36'sd2 * (pr[5] - pr[6]);
    e[6] = 36'sd2 * (pr[4] - pr[7]);
    e[7] = 36'sd2 * (pr[5] + pr[6]);
    e[8] = 36'(bpcc_pkg::One30) - 36'sd2 * (pr[0] + pr[1]);
    for (int i = 0; i < 9; i++) begin
      s2_d.rmat[i] = bpcc_pkg::clamp_r(e[i]);
    end
    s2_d.tag = s1_tag_q;
    s2_d.pos = s1_pos_q;
    s2_d.dim = s1_dim_q;
  end

  assign s1_vld_d = adv1 ? in_valid : s1_vld_q;
  assign s2_vld_d = adv2 ? s1_vld_q : s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid) begin
      s1_prd_q <= s1_prd_d;
      s1_tag_q <= pair_tag_i;
      s1_pos_q <= {box_pz_i, box_py_i, box_px_i};
      s1_dim_q <= {size_z_i, size_y_i, size_x_i};
    end
    if (adv2 && s1_vld_q) begin
      s2_q <= s2_d;
    end
  end

  assign box_valid_o = s2_vld_q;
  assign box_o       = s2_q;

endmodule

// ----- sv/bpcc_queue.sv -----
// Short FIFO of boxes between the front and back ends.
module bpcc_queue #(
  parameter int unsigned Depth = bpcc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  bpcc_pkg::box_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output bpcc_pkg::box_t rd_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  bpcc_pkg::box_t mem_q [Depth];
  logic [AW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]    cnt_q, cnt_d;
  logic           wr, rd;

  assign wr_stall_o = (cnt_q == (AW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;
  assign rd_data_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    if (wr) wp_d = (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    if (rd) rp_d = (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    cnt_d = cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_stall_o |-> !wr) else $error("write into full queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count step");

endmodule

// ----- sv/bpcc_back.sv -----
// Back end: pipelines the eight corners of one box, one corner per cycle unless stalled.
module bpcc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bpcc_pkg::plane_t plane_i,
  input  logic             box_valid_i,
  output logic             box_stall_o,
  input  bpcc_pkg::box_t   box_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      tag_out_o,
  output logic             hit_o,
  output logic [2:0]       corner_o,
  output logic signed [31:0] contact_x_o,
  output logic signed [31:0] contact_y_o,
  output logic signed [31:0] contact_z_o,
  output logic signed [31:0] depth_o,
  output logic             last_o
);

  // Stage A: issue corner, form 9 products r_kj * (+/-dim_j).
  // Stage B: sums, shift, add centre, saturate.
  // Stage C: normal products.  Stage D: distance and test.
  // Stage E: hold touching contact until the next one or the end is known.
  typedef struct packed {
    logic        [15:0] tag;
    logic        [2:0]  corner;
    logic               lastc;
  } ctl_t;

  logic [2:0]  cidx_q, cidx_d;
  logic        adv;
  logic        issue;

  logic              a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  ctl_t              a_ctl_q, b_ctl_q, c_ctl_q, d_ctl_q;
  logic signed [8:0][63:0] a_prd_q, a_prd_d;
  logic signed [2:0][31:0] a_pos_q;
  logic signed [2:0][31:0] b_pt_q, b_pt_d, c_pt_q, d_pt_q;
  logic signed [2:0][63:0] c_np_q, c_np_d;
  logic              d_touch_q, d_touch_d;
  logic signed [31:0] d_depth_q, d_depth_d;

  // Hold register for one pending contact, and output register.
  logic              h_vld_q;
  logic              h_last_q;
  logic        [15:0] h_tag_q;
  logic        [2:0] h_cor_q;
  logic signed [2:0][31:0] h_pt_q;
  logic signed [31:0] h_dep_q;
  logic              o_vld_q;

  logic emit_held, emit_dir, emit_miss, emit_last, hold_load, hold_clr;

  // The pipeline moves as a whole whenever the output register can take a result.
  assign adv = !o_vld_q || !out_stall;
  assign issue = adv && box_valid_i;
  assign box_stall_o = !(issue && cidx_q == 3'd7);
  assign cidx_d = issue ? cidx_q + 1'b1 : cidx_q;

  always_comb begin
    logic signed [31:0] sd [3];
    sd[0] = cidx_q[2] ? 32'($signed({1'b0, box_i.dim[0]})) : -32'($signed({1'b0, box_i.dim[0]}));
    sd[1] = cidx_q[1] ? 32'($signed({1'b0, box_i.dim[1]})) : -32'($signed({1'b0, box_i.dim[1]}));
    sd[2] = cidx_q[0] ? 32'($signed({1'b0, box_i.dim[2]})) : -32'($signed({1'b0, box_i.dim[2]}));
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        a_prd_d[k*3+j] = $signed(box_i.rmat[k*3+j]) * sd[j];
      end
    end
  end

  // Half size sits in the shift: one more than the fraction bits of the matrix.
  localparam int unsigned OffShift = 31;

  always_comb begin
    logic signed [65:0] acc;
    logic signed [35:0] off;
    for (int k = 0; k < 3; k++) begin
      acc = 66'($signed(a_prd_q[k*3])) + 66'($signed(a_prd_q[k*3+1])) +
            66'($signed(a_prd_q[k*3+2]));
      off = 36'(acc >>> OffShift);
      b_pt_d[k] = bpcc_pkg::sat32(36'($signed(a_pos_q[k])) + off);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_np_d[k] = $signed(plane_i.nn[k]) *
                  (33'($signed(b_pt_q[k])) - 33'($signed(plane_i.pp[k])));
    end
  end

  always_comb begin
    logic signed [35:0] sdist;
    sdist = 36'($signed(c_np_q[0]) >>> 30) + 36'($signed(c_np_q[1]) >>> 30) +
            36'($signed(c_np_q[2]) >>> 30);
    d_touch_d = sdist < 36'($signed({1'b0, plane_i.margin}));
    if (sdist >= 0) begin
      d_depth_d = '0;
    end else if (sdist < -36'sd2147483648) begin
      d_depth_d = 32'sh80000000;
    end else begin
      d_depth_d = sdist[31:0];
    end
  end

  // Output decisions from stage D. When the last corner touches while an
  // earlier contact is held, the held one goes out first and the last corner
  // waits in the hold register, marked final, until the output takes it.
  always_comb begin
    emit_held = 1'b0;
    emit_dir  = 1'b0;
    emit_miss = 1'b0;
    emit_last = 1'b0;
    hold_load = 1'b0;
    hold_clr  = 1'b0;
    if (adv) begin
      if (h_vld_q && h_last_q) begin
        emit_held = 1'b1;
        emit_last = 1'b1;
        hold_clr  = 1'b1;
      end
      if (d_vld_q) begin
        if (d_touch_q) begin
          if (d_ctl_q.lastc && !h_vld_q) begin
            emit_dir  = 1'b1;
            emit_last = 1'b1;
          end else begin
            hold_load = 1'b1;
            emit_held = emit_held || h_vld_q;
          end
        end else if (d_ctl_q.lastc) begin
          if (h_vld_q) begin
            emit_held = 1'b1;
            emit_last = 1'b1;
            hold_clr  = 1'b1;
          end else begin
            emit_miss = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cidx_q   <= '0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      h_vld_q  <= 1'b0;
      h_last_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      cidx_q <= cidx_d;
      if (adv) begin
        a_vld_q <= issue;
        b_vld_q <= a_vld_q;
        c_vld_q <= b_vld_q;
        d_vld_q <= c_vld_q;
        o_vld_q <= emit_held || emit_dir || emit_miss;
        if (hold_load) begin
          h_vld_q  <= 1'b1;
          h_last_q <= d_ctl_q.lastc;
        end else if (hold_clr) begin
          h_vld_q  <= 1'b0;
          h_last_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_prd_q <= a_prd_d;
      a_pos_q <= box_i.pos;
      a_ctl_q <= '{tag: box_i.tag, corner: cidx_q, lastc: (cidx_q == 3'd7)};
      b_ctl_q <= a_ctl_q;
      b_pt_q  <= b_pt_d;
      c_ctl_q <= b_ctl_q;
      c_pt_q  <= b_pt_q;
      c_np_q  <= c_np_d;
      d_ctl_q <= c_ctl_q;
      d_pt_q  <= c_pt_q;
      d_touch_q <= d_touch_d;
      d_depth_q <= d_depth_d;
      if (hold_load) begin
        h_tag_q <= d_ctl_q.tag;
        h_cor_q <= d_ctl_q.corner;
        h_pt_q  <= d_pt_q;
        h_dep_q <= d_depth_q;
      end
      if (emit_miss) begin
        tag_out_o   <= d_ctl_q.tag;
        hit_o       <= 1'b0;
        corner_o    <= '0;
        contact_x_o <= '0;
        contact_y_o <= '0;
        contact_z_o <= '0;
        depth_o     <= '0;
        last_o      <= 1'b1;
      end else if (emit_dir) begin
        tag_out_o   <= d_ctl_q.tag;
        hit_o       <= 1'b1;
        corner_o    <= d_ctl_q.corner;
        contact_x_o <= d_pt_q[0];
        contact_y_o <= d_pt_q[1];
        contact_z_o <= d_pt_q[2];
        depth_o     <= d_depth_q;
        last_o      <= 1'b1;
      end else if (emit_held) begin
        tag_out_o   <= h_tag_q;
        hit_o       <= 1'b1;
        corner_o    <= h_cor_q;
        contact_x_o <= h_pt_q[0];
        contact_y_o <= h_pt_q[1];
        contact_z_o <= h_pt_q[2];
        depth_o     <= h_dep_q;
        last_o      <= emit_last;
      end
    end
  end

  assign out_valid = o_vld_q;

  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && out_stall) |=> o_vld_q && $stable(depth_o))
    else $error("stalled result changed");
  a_depth_np: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q |-> !depth_o[31] || hit_o) else $error("miss with depth");
  a_last_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && cidx_q == 3'd7) |=> cidx_q == 3'd0) else $error("corner count");

endmodule

// ----- sv/box_plane_corner_contacts_top.sv -----
// Top level of the box/plane corner contact block with configuration registers.
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | pair_tag, box_p*, rot_*, size_*
//   out     | output    | out_valid/out_stall| tag_out, hit, corner, contact_*, depth, last
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A box holds the corner unit while its eight corners issue, one corner per cycle
// unless the output stalls; the next box is taken only after the last corner of
// the current one has issued. When the last corner and an earlier corner both
// touch, the final result passes through the hold register.
// Reset clears all control state and sets the plane registers to their defaults.
// A stall on the output halts the corner unit; the queue keeps taking boxes until full.
module box_plane_corner_contacts_top #(
  parameter int unsigned PosFracBits = bpcc_pkg::PosFracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      pair_tag_i,
  input  logic signed [31:0] box_px_i,
  input  logic signed [31:0] box_py_i,
  input  logic signed [31:0] box_pz_i,
  input  logic signed [31:0] rot_w_i,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  input  logic [30:0]      size_x_i,
  input  logic [30:0]      size_y_i,
  input  logic [30:0]      size_z_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [15:0]      tag_out_o,
  output logic             hit_o,
  output logic [2:0]       corner_o,
  output logic signed [31:0] contact_x_o,
  output logic signed [31:0] contact_y_o,
  output logic signed [31:0] contact_z_o,
  output logic signed [31:0] depth_o,
  output logic             last_o,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  bpcc_pkg::plane_t plane_q;
  bpcc_pkg::box_t   f_box, q_box;
  logic             f_vld, f_stall, q_vld, q_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q.margin <= 31'(((64'd1 << PosFracBits) + 64'd50) / 64'd100);
      plane_q.pp     <= '0;
      plane_q.nn     <= {32'sd0, bpcc_pkg::One30, 32'sd0};
    end else if (cfg_valid) begin
      case (cfg_index_i)
        bpcc_pkg::CfgMargin: plane_q.margin <= cfg_data_i[30:0];
        bpcc_pkg::CfgPpX:    plane_q.pp[0]  <= cfg_data_i;
        bpcc_pkg::CfgPpY:    plane_q.pp[1]  <= cfg_data_i;
        bpcc_pkg::CfgPpZ:    plane_q.pp[2]  <= cfg_data_i;
        bpcc_pkg::CfgNX:     plane_q.nn[0]  <= cfg_data_i;
        bpcc_pkg::CfgNY:     plane_q.nn[1]  <= cfg_data_i;
        bpcc_pkg::CfgNZ:     plane_q.nn[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpcc_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .pair_tag_i, .box_px_i, .box_py_i, .box_pz_i,
    .rot_w_i, .rot_x_i, .rot_y_i, .rot_z_i,
    .size_x_i, .size_y_i, .size_z_i,
    .box_valid_o(f_vld), .box_stall_i(f_stall), .box_o(f_box)
  );

  bpcc_queue #(.Depth(bpcc_pkg::QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_vld), .wr_stall_o(f_stall), .wr_data_i(f_box),
    .rd_valid_o(q_vld), .rd_stall_i(q_stall), .rd_data_o(q_box)
  );

  bpcc_back u_back (
    .clk_i, .rst_ni, .plane_i(plane_q),
    .box_valid_i(q_vld), .box_stall_o(q_stall), .box_i(q_box),
    .out_valid, .out_stall, .tag_out_o, .hit_o, .corner_o,
    .contact_x_o, .contact_y_o, .contact_z_o, .depth_o, .last_o
  );

endmodule
